// File: design/wsw_pkg.sv
// Shared types and constants for the worker stall watchdog.
package wsw_pkg;

    localparam int NUM_WORKERS_DEF  = 16;
    localparam int VERSION_BITS_DEF = 32;

    localparam int JOB_W  = 32;
    localparam int WIDX_W = 4;
    localparam int SCAN_W = 5;

    localparam logic [SCAN_W-1:0] SCAN_COUNT_RESET = 5'd16;

    typedef enum logic [1:0] {
        MODE_TRIGGER = 2'd0,
        MODE_CHECK   = 2'd1,
        MODE_CREATE  = 2'd2,
        MODE_REMOVE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_EDIT  = 2'd1,
        ST_SCAN  = 2'd2,
        ST_FLUSH = 2'd3
    } state_t;

endpackage

// File: design/wsw_cell.sv
// One worker entry of the rotating ring, with a registered stale flag.
module wsw_cell #(
    parameter int VERSION_BITS = wsw_pkg::VERSION_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     d_valid,
    input  logic [VERSION_BITS-1:0]  d_ver,
    input  logic [VERSION_BITS-1:0]  d_seen,
    input  logic [wsw_pkg::JOB_W-1:0] d_job,
    output logic                     q_valid,
    output logic [VERSION_BITS-1:0]  q_ver,
    output logic [VERSION_BITS-1:0]  q_seen,
    output logic [wsw_pkg::JOB_W-1:0] q_job,
    output logic                     q_stale
);

    logic                      valid_reg;
    logic [VERSION_BITS-1:0]   ver_reg;
    logic [VERSION_BITS-1:0]   seen_reg;
    logic [wsw_pkg::JOB_W-1:0] job_reg;
    logic                      stale_reg;
    logic                      stale_next;

    // The version compare is done on the way in, so the head sees one flop.
    assign stale_next = (d_ver == d_seen);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ver_reg   <= '0;
            seen_reg  <= '0;
            job_reg   <= '0;
            stale_reg <= 1'b1;
        end
        else
        begin
            valid_reg <= d_valid;
            ver_reg   <= d_ver;
            seen_reg  <= d_seen;
            job_reg   <= d_job;
            stale_reg <= stale_next;
        end
    end

    assign q_valid = valid_reg;
    assign q_ver   = ver_reg;
    assign q_seen  = seen_reg;
    assign q_job   = job_reg;
    assign q_stale = stale_reg;

endmodule

// File: design/wsw_ctrl.sv
// Head controller: edits the entry at the ring head, runs check scans, drives results.
module wsw_ctrl #(
    parameter int NUM_WORKERS  = wsw_pkg::NUM_WORKERS_DEF,
    parameter int VERSION_BITS = wsw_pkg::VERSION_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 mode,
    input  logic [wsw_pkg::WIDX_W-1:0] worker_index,
    input  logic [wsw_pkg::JOB_W-1:0]  job_id,
    input  logic                       workers_running,
    input  logic [wsw_pkg::SCAN_W-1:0] scan_count,
    input  logic                       head_valid,
    input  logic [VERSION_BITS-1:0]    head_ver,
    input  logic [VERSION_BITS-1:0]    head_seen,
    input  logic [wsw_pkg::JOB_W-1:0]  head_job,
    input  logic                       head_stale,
    output logic                       wb_valid,
    output logic [VERSION_BITS-1:0]    wb_ver,
    output logic [VERSION_BITS-1:0]    wb_seen,
    output logic [wsw_pkg::JOB_W-1:0]  wb_job,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [wsw_pkg::JOB_W-1:0]  stalled_job,
    output logic [wsw_pkg::WIDX_W-1:0] stalled_worker,
    output logic                       last_report
);

    localparam int IDX_W = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
    localparam int CNT_W = $clog2(NUM_WORKERS + 1);

    wsw_pkg::state_t state_reg, state_next;
    wsw_pkg::mode_t  mode_reg,  mode_next;

    logic [IDX_W-1:0]           head_reg,     head_next;
    logic [IDX_W-1:0]           target_reg,   target_next;
    logic [wsw_pkg::JOB_W-1:0]  job_reg,      job_next;
    logic [CNT_W-1:0]           ptr_reg,      ptr_next;
    logic [CNT_W-1:0]           limit_reg,    limit_next;
    logic                       pend_valid_reg, pend_valid_next;
    logic [wsw_pkg::JOB_W-1:0]  pend_job_reg,   pend_job_next;
    logic [wsw_pkg::WIDX_W-1:0] pend_idx_reg,   pend_idx_next;
    logic                       out_valid_reg,  out_valid_next;
    logic [wsw_pkg::JOB_W-1:0]  out_job_reg,    out_job_next;
    logic [wsw_pkg::WIDX_W-1:0] out_idx_reg,    out_idx_next;
    logic                       out_last_reg,   out_last_next;

    logic        out_free;
    logic        accept;
    logic        idx_ok;
    logic [31:0] scan_wide;

    assign out_free  = !out_valid_reg || out_ready;
    assign accept    = in_valid && (state_reg == wsw_pkg::ST_IDLE);
    assign idx_ok    = (32'(worker_index) < NUM_WORKERS);
    assign scan_wide = 32'(scan_count);

    // The ring turns every cycle, so the head pointer just counts around.
    assign head_next = (head_reg == IDX_W'(NUM_WORKERS - 1)) ? '0 : head_reg + IDX_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        target_next     = target_reg;
        job_next        = job_reg;
        ptr_next        = ptr_reg;
        limit_next      = limit_reg;
        pend_valid_next = pend_valid_reg;
        pend_job_next   = pend_job_reg;
        pend_idx_next   = pend_idx_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_job_next    = out_job_reg;
        out_idx_next    = out_idx_reg;
        out_last_next   = out_last_reg;
        wb_valid        = head_valid;
        wb_ver          = head_ver;
        wb_seen         = head_seen;
        wb_job          = head_job;

        unique case (state_reg)
            wsw_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next   = wsw_pkg::mode_t'(mode);
                    target_next = IDX_W'(worker_index);
                    job_next    = job_id;
                    ptr_next    = '0;
                    limit_next  = (scan_wide > NUM_WORKERS) ? CNT_W'(NUM_WORKERS)
                                                            : CNT_W'(scan_count);
                    if (mode == wsw_pkg::MODE_CHECK)
                    begin
                        if (workers_running)
                            state_next = wsw_pkg::ST_SCAN;
                    end
                    else if (idx_ok)
                    begin
                        state_next = wsw_pkg::ST_EDIT;
                    end
                end
            end

            wsw_pkg::ST_EDIT:
            begin
                if (head_reg == target_reg)
                begin
                    state_next = wsw_pkg::ST_IDLE;
                    unique case (mode_reg)
                        wsw_pkg::MODE_TRIGGER:
                        begin
                            if (head_valid)
                            begin
                                wb_ver = head_ver + VERSION_BITS'(1);
                                wb_job = job_reg;
                            end
                        end
                        wsw_pkg::MODE_CREATE:
                        begin
                            if (!head_valid)
                            begin
                                wb_valid = 1'b1;
                                wb_ver   = '0;
                                wb_seen  = '0;
                                wb_job   = '0;
                            end
                        end
                        wsw_pkg::MODE_REMOVE:
                        begin
                            wb_valid = 1'b0;
                            wb_ver   = '0;
                            wb_seen  = '0;
                            wb_job   = '0;
                        end
                        wsw_pkg::MODE_CHECK:
                        begin
                            wb_valid = head_valid;
                        end
                    endcase
                end
            end

            wsw_pkg::ST_SCAN:
            begin
                priority if (ptr_reg == limit_reg)
                begin
                    state_next = wsw_pkg::ST_FLUSH;
                end
                else if (head_reg == ptr_reg[IDX_W-1:0])
                begin
                    priority if (!head_valid)
                    begin
                        state_next = wsw_pkg::ST_FLUSH;
                    end
                    else if (head_stale && (head_job != '0))
                    begin
                        // A report waits in the pending slot until the next one
                        // (or the end of the scan) tells whether it is the last.
                        // If the slot cannot drain, the entry is retried next turn.
                        if (!pend_valid_reg || out_free)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_valid_next = 1'b1;
                                out_job_next   = pend_job_reg;
                                out_idx_next   = pend_idx_reg;
                                out_last_next  = 1'b0;
                            end
                            pend_valid_next = 1'b1;
                            pend_job_next   = head_job;
                            pend_idx_next   = wsw_pkg::WIDX_W'(head_reg);
                            ptr_next        = ptr_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        wb_seen  = head_ver;
                        ptr_next = ptr_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    // The next entry to scan has not reached the head yet.
                    state_next = wsw_pkg::ST_SCAN;
                end
            end

            wsw_pkg::ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = wsw_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_job_next    = pend_job_reg;
                    out_idx_next    = pend_idx_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = wsw_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= wsw_pkg::ST_IDLE;
            head_reg       <= '0;
            ptr_reg        <= '0;
            limit_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            ptr_reg        <= ptr_next;
            limit_reg      <= limit_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        target_reg   <= target_next;
        job_reg      <= job_next;
        pend_job_reg <= pend_job_next;
        pend_idx_reg <= pend_idx_next;
        out_job_reg  <= out_job_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
    end

    assign in_ready       = (state_reg == wsw_pkg::ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign stalled_job    = out_job_reg;
    assign stalled_worker = out_idx_reg;
    assign last_report    = out_last_reg;

`ifndef SYNTHESIS
    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wsw_pkg::ST_SCAN) |-> (ptr_reg <= limit_reg))
        else $error("scan pointer ran past the scan limit");

    a_limit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        limit_reg <= CNT_W'(NUM_WORKERS))
        else $error("scan limit exceeds the table size");

    a_no_pending_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wsw_pkg::ST_IDLE) |-> !pend_valid_reg)
        else $error("pending report left behind after a check");

    a_flush_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == wsw_pkg::ST_FLUSH) && pend_valid_reg && out_free)
        |=> (out_valid_reg && out_last_reg))
        else $error("final report of a check not flagged as last");
`endif

endmodule

// File: design/worker_stall_watchdog_unit.sv
// Worker stall watchdog: ring of entry cells turned past a head controller.
// Entries rotate one cell per cycle; one item at a time, the next taken once in_ready returns.
// Trigger, create and remove hold in_ready low while they wait for the entry to reach the head.
// A check waits for entry 0 to reach the head, then scans each entry as it passes the head,
// and closes via the flush state; a report finding the output occupied waits a ring turn.
// Reset clears every entry to invalid and zero and sets scan_count to 16.
module worker_stall_watchdog_unit #(
    parameter int NUM_WORKERS  = wsw_pkg::NUM_WORKERS_DEF,
    parameter int VERSION_BITS = wsw_pkg::VERSION_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [wsw_pkg::SCAN_W-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 mode,
    input  logic [wsw_pkg::WIDX_W-1:0] worker_index,
    input  logic [wsw_pkg::JOB_W-1:0]  job_id,
    input  logic                       workers_running,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [wsw_pkg::JOB_W-1:0]  stalled_job,
    output logic [wsw_pkg::WIDX_W-1:0] stalled_worker,
    output logic                       last_report
);

    logic [wsw_pkg::SCAN_W-1:0] scan_count_reg;

    logic                      ring_valid [NUM_WORKERS];
    logic [VERSION_BITS-1:0]   ring_ver   [NUM_WORKERS];
    logic [VERSION_BITS-1:0]   ring_seen  [NUM_WORKERS];
    logic [wsw_pkg::JOB_W-1:0] ring_job   [NUM_WORKERS];
    logic                      ring_stale [NUM_WORKERS];

    logic                      wb_valid;
    logic [VERSION_BITS-1:0]   wb_ver;
    logic [VERSION_BITS-1:0]   wb_seen;
    logic [wsw_pkg::JOB_W-1:0] wb_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scan_count_reg <= wsw_pkg::SCAN_COUNT_RESET;
        else if (cfg_valid)
            scan_count_reg <= cfg_data;
    end

    // Cell 0 is the head; the edited head entry re-enters at the tail cell.
    for (genvar i = 0; i < NUM_WORKERS; i++)
    begin : g_cell
        if (i == NUM_WORKERS - 1)
        begin : g_tail
            wsw_cell #(
                .VERSION_BITS(VERSION_BITS)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .d_valid (wb_valid),
                .d_ver   (wb_ver),
                .d_seen  (wb_seen),
                .d_job   (wb_job),
                .q_valid (ring_valid[i]),
                .q_ver   (ring_ver[i]),
                .q_seen  (ring_seen[i]),
                .q_job   (ring_job[i]),
                .q_stale (ring_stale[i])
            );
        end
        else
        begin : g_body
            wsw_cell #(
                .VERSION_BITS(VERSION_BITS)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .d_valid (ring_valid[i+1]),
                .d_ver   (ring_ver[i+1]),
                .d_seen  (ring_seen[i+1]),
                .d_job   (ring_job[i+1]),
                .q_valid (ring_valid[i]),
                .q_ver   (ring_ver[i]),
                .q_seen  (ring_seen[i]),
                .q_job   (ring_job[i]),
                .q_stale (ring_stale[i])
            );
        end
    end

    wsw_ctrl #(
        .NUM_WORKERS  (NUM_WORKERS),
        .VERSION_BITS (VERSION_BITS)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .worker_index    (worker_index),
        .job_id          (job_id),
        .workers_running (workers_running),
        .scan_count      (scan_count_reg),
        .head_valid      (ring_valid[0]),
        .head_ver        (ring_ver[0]),
        .head_seen       (ring_seen[0]),
        .head_job        (ring_job[0]),
        .head_stale      (ring_stale[0]),
        .wb_valid        (wb_valid),
        .wb_ver          (wb_ver),
        .wb_seen         (wb_seen),
        .wb_job          (wb_job),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .stalled_job     (stalled_job),
        .stalled_worker  (stalled_worker),
        .last_report     (last_report)
    );

endmodule
